[rtl/bgd_pkg.sv]
// Shared types and constants for the button gesture detector.
// Used by bgd_front, bgd_queue, bgd_back and button_gesture_detector.
`default_nettype none

package bgd_pkg;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LONGHOLD     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REPEAT_FIRST = 3'd2;
  localparam logic [CFG_AW-1:0] REG_REPEAT       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DBLCLICK     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FILTER_EN    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STATE_MASK   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_ACTION_MASK  = 3'd7;

  // Register reset values.
  localparam logic [2:0]  MODE_RST          = 3'd0;
  localparam logic [15:0] LONGHOLD_RST      = 16'd1000;
  localparam logic [15:0] REPEAT_FIRST_RST  = 16'd500;
  localparam logic [15:0] REPEAT_RST        = 16'd100;
  localparam logic [15:0] DBLCLICK_RST      = 16'd300;
  localparam logic [3:0]  MASK_RST          = 4'hf;

  // Mode bit positions; all zero selects simple mode.
  localparam logic [2:0] MODE_SIMPLE = 3'd0;
  localparam int MB_DOUBLE = 0;
  localparam int MB_LONG   = 1;
  localparam int MB_REPEAT = 2;

  // Flag word bits.
  localparam logic [3:0] F_NONE      = 4'h0;
  localparam logic [3:0] F_PRESSED   = 4'h1;
  localparam logic [3:0] F_DOUBLED   = 4'h2;
  localparam logic [3:0] F_LONG      = 4'h4;
  localparam logic [3:0] F_REPEATING = 4'h8;

  // Request and event kinds.
  localparam logic REQ_LEVEL    = 1'b0;
  localparam logic REQ_TICK     = 1'b1;
  localparam logic KIND_STATE   = 1'b0;
  localparam logic KIND_ACTION  = 1'b1;

  // Event queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       kind;
    logic [3:0] flags;
    logic       last;
  } bgd_ev_t;

  // Up to two events produced by one accepted word.
  typedef struct packed {
    logic [1:0] n;
    bgd_ev_t    ev0;
    bgd_ev_t    ev1;
  } bgd_push_t;

endpackage

`default_nettype wire

[rtl/bgd_front.sv]
// Front part: configuration registers, gesture state machine, timer and
// event filter. Produces up to two events per accepted word. Uses bgd_pkg.
`default_nettype none

module bgd_front #(
  parameter int TICK_WIDTH = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [bgd_pkg::CFG_AW-1:0] cfg_addr,
  input  wire [bgd_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire                       in_valid,
  input  wire                       in_req,
  input  wire                       in_level,
  output logic                      in_ready,
  input  wire                       space_ok,
  output bgd_pkg::bgd_push_t        push
);
  import bgd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRESSED, ST_WAIT_DBL, ST_DBL, ST_HOLD
  } gst_t;

  localparam logic [32:0] TICK_MAX = (33'd1 << TICK_WIDTH) - 33'd1;

  logic [2:0]            mode_r;
  logic [15:0]           longhold_r, rep_first_r, rep_r, dbl_r;
  logic                  fen_r;
  logic [3:0]            smask_r, amask_r;

  gst_t                  st_r, st_nxt;
  logic [3:0]            fl_r, fl_nxt;
  logic [TICK_WIDTH-1:0] cd_r, cd_nxt;
  logic                  armd_r, armd_nxt;

  logic [1:0]            pv, pk, ok;
  logic [1:0][3:0]       pf;
  logic                  fire;
  logic                  rel, lng, rpt;

  // Tick counts wider than the countdown saturate.
  function automatic logic [TICK_WIDTH-1:0] sat(input logic [15:0] t);
    if ({17'd0, t} > TICK_MAX) return TICK_MAX[TICK_WIDTH-1:0];
    else return TICK_WIDTH'(t);
  endfunction

  assign in_ready = space_ok;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RST;
      longhold_r  <= LONGHOLD_RST;
      rep_first_r <= REPEAT_FIRST_RST;
      rep_r       <= REPEAT_RST;
      dbl_r       <= DBLCLICK_RST;
      fen_r       <= 1'b0;
      smask_r     <= MASK_RST;
      amask_r     <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:         mode_r      <= cfg_wdata[2:0];
        REG_LONGHOLD:     longhold_r  <= cfg_wdata;
        REG_REPEAT_FIRST: rep_first_r <= cfg_wdata;
        REG_REPEAT:       rep_r       <= cfg_wdata;
        REG_DBLCLICK:     dbl_r       <= cfg_wdata;
        REG_FILTER_EN:    fen_r       <= cfg_wdata[0];
        REG_STATE_MASK:   smask_r     <= cfg_wdata[3:0];
        REG_ACTION_MASK:  amask_r     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0] n;
    n        = 2'd0;
    st_nxt   = st_r;
    fl_nxt   = fl_r;
    cd_nxt   = cd_r;
    armd_nxt = armd_r;
    pv       = '0;
    pk       = '0;
    pf       = '0;
    rel      = 1'b0;
    lng      = 1'b0;
    rpt      = 1'b0;

    if (in_req == REQ_TICK) begin
      if (armd_r) begin
        if (cd_r <= TICK_WIDTH'(1)) begin
          cd_nxt   = '0;
          armd_nxt = 1'b0;
          case (st_r)
            ST_PRESSED, ST_DBL: begin
              if (mode_r[MB_LONG]) lng = 1'b1;
              else if (mode_r[MB_REPEAT]) rpt = 1'b1;
            end
            ST_WAIT_DBL: rel = 1'b1;
            ST_HOLD:     rpt = mode_r[MB_REPEAT];
            default: ;
          endcase
        end else begin
          cd_nxt = cd_r - TICK_WIDTH'(1);
        end
      end
    end else if (mode_r == MODE_SIMPLE) begin
      if (in_level) begin
        fl_nxt = F_PRESSED;
      end else begin
        pv[n[0]] = 1'b1; pk[n[0]] = KIND_ACTION; pf[n[0]] = fl_r; n = n + 2'd1;
        fl_nxt = fl_r & ~F_PRESSED;
      end
      pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = fl_nxt; n = n + 2'd1;
    end else if (in_level) begin
      case (st_r)
        ST_PRESSED, ST_DBL, ST_HOLD: ;
        ST_WAIT_DBL: begin
          if (mode_r[MB_LONG]) begin
            cd_nxt = sat(longhold_r); armd_nxt = 1'b1;
          end else if (mode_r[MB_REPEAT]) begin
            cd_nxt = sat(rep_first_r); armd_nxt = 1'b1;
          end else begin
            armd_nxt = 1'b0;
          end
          fl_nxt = fl_r | F_DOUBLED;
          pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = fl_nxt; n = n + 2'd1;
          st_nxt = ST_DBL;
        end
        default: begin
          // Idle and the unused codes start a new press.
          if (mode_r[MB_LONG]) begin
            cd_nxt = sat(longhold_r); armd_nxt = 1'b1;
          end else if (mode_r[MB_REPEAT]) begin
            cd_nxt = sat(rep_first_r); armd_nxt = 1'b1;
          end
          fl_nxt = F_PRESSED;
          pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = F_PRESSED; n = n + 2'd1;
          st_nxt = ST_PRESSED;
        end
      endcase
    end else begin
      case (st_r)
        ST_PRESSED: begin
          if (mode_r[MB_DOUBLE]) begin
            cd_nxt   = sat(dbl_r);
            armd_nxt = 1'b1;
            st_nxt   = ST_WAIT_DBL;
          end else begin
            rel = 1'b1;
          end
        end
        ST_DBL, ST_HOLD: rel = 1'b1;
        default: ;
      endcase
    end

    if (rel) begin
      armd_nxt = 1'b0;
      if ((fl_r & F_REPEATING) == F_NONE) begin
        pv[n[0]] = 1'b1; pk[n[0]] = KIND_ACTION; pf[n[0]] = fl_r; n = n + 2'd1;
      end
      fl_nxt = fl_r & ~F_PRESSED;
      pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = fl_nxt; n = n + 2'd1;
      st_nxt = ST_IDLE;
    end
    if (lng) begin
      if (mode_r[MB_REPEAT]) begin
        cd_nxt = sat(rep_first_r); armd_nxt = 1'b1;
      end
      fl_nxt = fl_r | F_LONG;
      pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = fl_nxt; n = n + 2'd1;
      st_nxt = ST_HOLD;
    end
    if (rpt) begin
      cd_nxt   = sat(rep_r);
      armd_nxt = 1'b1;
      pv[n[0]] = 1'b1; pk[n[0]] = KIND_ACTION; pf[n[0]] = fl_r; n = n + 2'd1;
      if ((fl_r & F_REPEATING) == F_NONE) begin
        fl_nxt = fl_r | F_REPEATING;
        pv[n[0]] = 1'b1; pk[n[0]] = KIND_STATE; pf[n[0]] = fl_nxt; n = n + 2'd1;
      end
    end
  end

  // Filter, then close the gap if the first event was dropped.
  always_comb begin
    logic [3:0] m0, m1;
    m0 = (pk[0] == KIND_STATE) ? smask_r : amask_r;
    m1 = (pk[1] == KIND_STATE) ? smask_r : amask_r;
    ok[0] = pv[0] && (!fen_r || ((~m0 & pf[0]) == F_NONE));
    ok[1] = pv[1] && (!fen_r || ((~m1 & pf[1]) == F_NONE));

    push.n   = 2'd0;
    push.ev0 = '{kind: pk[0], flags: pf[0], last: 1'b0};
    push.ev1 = '{kind: pk[1], flags: pf[1], last: 1'b1};
    if (ok[0] && ok[1]) begin
      push.n = 2'd2;
    end else if (ok[0] || ok[1]) begin
      push.n = 2'd1;
      if (!ok[0]) push.ev0 = push.ev1;
      push.ev0.last = 1'b1;
    end
    if (!fire) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fl_r   <= F_NONE;
      cd_r   <= '0;
      armd_r <= 1'b0;
    end else if (fire) begin
      st_r   <= st_nxt;
      fl_r   <= fl_nxt;
      cd_r   <= cd_nxt;
      armd_r <= armd_nxt;
    end
  end

  a_tick_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_req == REQ_TICK && !armd_r |-> push.n == 2'd0)
    else $error("tick with timer disarmed produced an event");

  a_last_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> !push.ev0.last && push.ev1.last)
    else $error("last marker misplaced on a two-event word");

  a_simple_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_req == REQ_LEVEL && mode_r == MODE_SIMPLE |=>
      st_r == $past(st_r) && armd_r == $past(armd_r))
    else $error("simple mode touched gesture state or timer");

endmodule

`default_nettype wire

[rtl/bgd_queue.sv]
// Short event queue between front and back: up to two pushes and one pop a cycle.
// Depth from bgd_pkg::QDEPTH.
`default_nettype none

module bgd_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire bgd_pkg::bgd_push_t push,
  output logic                    space_ok,
  output logic                    head_valid,
  output bgd_pkg::bgd_ev_t        head,
  input  wire                     pop
);
  import bgd_pkg::*;

  bgd_ev_t          buf_r [QDEPTH];
  logic [QAW-1:0]   wp_r, rp_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  // Room for a full two-event word must exist before a word is taken.
  assign space_ok   = cnt_r <= (QAW+1)'(QDEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = buf_r[rp_r];
  assign cnt_nxt    = cnt_r + (QAW+1)'(push.n) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) buf_r[wp_r] <= push.ev0;
    if (push.n == 2'd2) buf_r[wp_r + QAW'(1)] <= push.ev1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QAW'(push.n);
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> cnt_r + (QAW+1)'(push.n) <= (QAW+1)'(QDEPTH))
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty event queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_nxt))
    else $error("queue count out of step");

endmodule

`default_nettype wire

[rtl/bgd_back.sv]
// Back part: output register that drains the event queue onto the result
// channel. Uses bgd_pkg.
`default_nettype none

module bgd_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   head_valid,
  input  wire bgd_pkg::bgd_ev_t head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import bgd_pkg::*;

  logic    vld_r;
  bgd_ev_t ev_r;

  assign pop        = head_valid && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign out_tdata  = {4'd0, ev_r.flags};
  assign out_tuser  = ev_r.kind;
  assign out_tlast  = ev_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_tready) begin
      vld_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ev_r <= head;
  end

endmodule

`default_nettype wire

[rtl/button_gesture_detector.sv]
// Top level of the button gesture detector: front, event queue, back.
// Depends on bgd_pkg, bgd_front, bgd_queue and bgd_back.
//
//   port group   direction  contents
//   in_*         in         tuser: req_type; tdata[0]: pressed_level
//   out_*        out        tuser: event_kind; tdata[3:0]: event_flags; tlast
//   cfg_*        in         write enable, register index, 16-bit data
//
// A word is taken in the cycle it is offered while the event queue holds two
// events or fewer; its events are registered in the queue and then in the
// output register. The result port moves one event a cycle while out_tready
// is high; new words are taken while earlier events still wait in the queue.
// Reset is synchronous, active low, and clears state, timer and queue.
// A stall on the result side fills the queue and then holds in_tready low.
`default_nettype none

module button_gesture_detector #(
  parameter int TICK_WIDTH = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [bgd_pkg::CFG_AW-1:0] cfg_addr,
  input  wire [bgd_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire [7:0]                 in_tdata,   // [0] pressed_level
  input  wire                       in_tuser,   // [0] req_type
  output logic                      out_tvalid,
  input  wire                       out_tready,
  output logic [7:0]                out_tdata,  // [3:0] event_flags
  output logic                      out_tuser,  // [0] event_kind
  output logic                      out_tlast
);
  import bgd_pkg::*;

  bgd_push_t push;
  bgd_ev_t   head;
  logic      space_ok, head_valid, pop;

  bgd_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_req   (in_tuser),
    .in_level (in_tdata[0]),
    .in_ready (in_tready),
    .space_ok (space_ok),
    .push     (push)
  );

  bgd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  bgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

[tb/button_gesture_detector_tb.sv]
// Self-checking testbench for button_gesture_detector: directed gestures, then random phases.
// Predicts every event from its own gesture model and compares it on the result stream.
// Depends on bgd_pkg and the button_gesture_detector RTL only.
`default_nettype none

module button_gesture_detector_tb;
  import bgd_pkg::*;

  typedef enum logic [2:0] {
    GS_IDLE     = 3'd0,
    GS_PRESSED  = 3'd1,
    GS_WAIT_DBL = 3'd2,
    GS_DBL      = 3'd3,
    GS_HOLD     = 3'd4
  } gesture_t;

  // Gesture predictor plus the queue of events it still expects on the result side.
  class gesture_model;
    logic [2:0]  mode;
    logic [15:0] longhold, rep_first, rep_gap, dbl_gap;
    logic        filt_en;
    logic [3:0]  state_mask, action_mask;
    gesture_t    st;
    logic [3:0]  flags;
    logic [15:0] countdown;
    logic        armed;
    bgd_ev_t     word_events[$];
    bgd_ev_t     pending_events[$];
    int unsigned errors;

    function new();
      mode        = MODE_RST;
      longhold    = LONGHOLD_RST;
      rep_first   = REPEAT_FIRST_RST;
      rep_gap     = REPEAT_RST;
      dbl_gap     = DBLCLICK_RST;
      filt_en     = 1'b0;
      state_mask  = MASK_RST;
      action_mask = MASK_RST;
      st          = GS_IDLE;
      flags       = F_NONE;
      countdown   = '0;
      armed       = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_MODE:         mode        = val[2:0];
        REG_LONGHOLD:     longhold    = val;
        REG_REPEAT_FIRST: rep_first   = val;
        REG_REPEAT:       rep_gap     = val;
        REG_DBLCLICK:     dbl_gap     = val;
        REG_FILTER_EN:    filt_en     = val[0];
        REG_STATE_MASK:   state_mask  = val[3:0];
        REG_ACTION_MASK:  action_mask = val[3:0];
        default: ;
      endcase
    endfunction

    // With a 16-bit countdown a 16-bit load never saturates.
    function void arm(logic [15:0] ticks);
      countdown = ticks;
      armed     = 1'b1;
    endfunction

    function void post(logic kind, logic [3:0] f);
      logic [3:0] mask;
      bgd_ev_t    ev;
      mask = (kind == KIND_STATE) ? state_mask : action_mask;
      if (filt_en && ((~mask & f) != F_NONE)) return;
      if (word_events.size() >= 2) return;
      ev.kind  = kind;
      ev.flags = f;
      ev.last  = 1'b0;
      word_events.push_back(ev);
    endfunction

    function void end_gesture();
      armed = 1'b0;
      if ((flags & F_REPEATING) == F_NONE) post(KIND_ACTION, flags);
      flags = flags & ~F_PRESSED;
      post(KIND_STATE, flags);
      st = GS_IDLE;
    endfunction

    function void fire_repeat();
      arm(rep_gap);
      post(KIND_ACTION, flags);
      if ((flags & F_REPEATING) == F_NONE) begin
        flags = flags | F_REPEATING;
        post(KIND_STATE, flags);
      end
    endfunction

    function void on_press();
      case (st)
        GS_PRESSED, GS_DBL, GS_HOLD: ;
        GS_WAIT_DBL: begin
          if (mode[MB_LONG]) arm(longhold);
          else if (mode[MB_REPEAT]) arm(rep_first);
          else armed = 1'b0;
          flags = flags | F_DOUBLED;
          post(KIND_STATE, flags);
          st = GS_DBL;
        end
        default: begin
          if (mode[MB_LONG]) arm(longhold);
          else if (mode[MB_REPEAT]) arm(rep_first);
          flags = F_PRESSED;
          post(KIND_STATE, flags);
          st = GS_PRESSED;
        end
      endcase
    endfunction

    function void on_release();
      case (st)
        GS_PRESSED: begin
          if (mode[MB_DOUBLE]) begin
            arm(dbl_gap);
            st = GS_WAIT_DBL;
          end else begin
            end_gesture();
          end
        end
        GS_DBL, GS_HOLD: end_gesture();
        default: ;
      endcase
    endfunction

    // A pending timer may expire after a switch to simple mode; it still runs here.
    function void on_timeout();
      case (st)
        GS_PRESSED, GS_DBL: begin
          if (mode[MB_LONG]) begin
            if (mode[MB_REPEAT]) arm(rep_first);
            flags = flags | F_LONG;
            post(KIND_STATE, flags);
            st = GS_HOLD;
          end else if (mode[MB_REPEAT]) begin
            fire_repeat();
          end
        end
        GS_WAIT_DBL: end_gesture();
        GS_HOLD: if (mode[MB_REPEAT]) fire_repeat();
        default: ;
      endcase
    endfunction

    // Predicts the events of one accepted word.
    function void take_word(logic req, logic lvl);
      bgd_ev_t ev;
      word_events.delete();
      if (req == REQ_TICK) begin
        if (armed) begin
          if (countdown <= 16'd1) begin
            countdown = '0;
            armed     = 1'b0;
            on_timeout();
          end else begin
            countdown = countdown - 16'd1;
          end
        end
      end else if (mode == MODE_SIMPLE) begin
        if (lvl) begin
          flags = F_PRESSED;
        end else begin
          post(KIND_ACTION, flags);
          flags = flags & ~F_PRESSED;
        end
        post(KIND_STATE, flags);
      end else if (lvl) begin
        on_press();
      end else begin
        on_release();
      end
      foreach (word_events[i]) begin
        ev      = word_events[i];
        ev.last = (i == word_events.size() - 1);
        pending_events.push_back(ev);
      end
    endfunction

    function void match_event(logic kind, logic [3:0] f, logic last);
      bgd_ev_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d flags %h last %0d", $time, kind, f, last);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (want.kind !== kind) begin
        $display("%0t: event kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (want.flags !== f) begin
        $display("%0t: event flags expected %h actual %h", $time, want.flags, f);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: event last expected %0d actual %0d", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_DW-1:0]   cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;  // [0] pressed_level
  logic                in_tuser   = 1'b0; // [0] req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;  // [3:0] event_flags
  logic                out_tuser;  // [0] event_kind
  logic                out_tlast;

  gesture_model sb = new();

  bit          long_stall_req = 1'b0;
  bit          pressure_done  = 1'b0;
  int unsigned burst_left     = 0;
  int unsigned sent_words     = 0;
  int unsigned phase_sent     = 0;
  int unsigned tick_span      = 8;
  int unsigned quiet_cycles   = 0;

  button_gesture_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.match_event(out_tuser, out_tdata[3:0], out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 4000) begin
        $display("FAIL button_gesture_detector");
        $finish;
      end
    end
  end

  // Receiver: a rotating stall pattern, redrawn at random, plus one long hold-off.
  initial begin : receiver
    logic [7:0]  pat;
    int unsigned k;
    pat = 8'hff;
    k   = 0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        if (k % 64 == 0) begin
          if ($urandom_range(0, 3) == 0) pat = 8'hff;
          else pat = 8'($urandom_range(1, 255));
        end
        out_tready <= pat[k % 8];
        k++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drains every expected event and lets the block settle before registers change.
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic offer(input logic req, input logic lvl);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    if (!pressure_done && sent_words >= 600) begin
      long_stall_req = 1'b1;
      pressure_done  = 1'b1;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, lvl};
    do @(posedge clk); while (!in_tready);
    sb.take_word(req, lvl);
    sent_words++;
    burst_left--;
    phase_sent++;
  endtask

  task automatic ticks(input int unsigned n);
    repeat (n) offer(REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_setup();
    int unsigned style;
    logic [15:0] t[4];
    style = $urandom_range(0, 9);
    foreach (t[i]) begin
      case (style)
        0:       t[i] = 16'hffff;
        1:       t[i] = 16'd1;
        default: t[i] = 16'($urandom_range(1, 6));
      endcase
    end
    tick_span = (style == 0) ? 10 : (style == 1) ? 6 : 24;
    write_reg(REG_MODE, 16'($urandom_range(0, 7)));
    write_reg(REG_LONGHOLD, t[0]);
    write_reg(REG_REPEAT_FIRST, t[1]);
    write_reg(REG_REPEAT, t[2]);
    write_reg(REG_DBLCLICK, t[3]);
    write_reg(REG_FILTER_EN, 16'($urandom_range(0, 2) == 0));
    write_reg(REG_STATE_MASK,
              16'($urandom_range(0, 3) == 0 ? 0 :
                  $urandom_range(0, 1) ? 15 : $urandom_range(0, 15)));
    write_reg(REG_ACTION_MASK,
              16'($urandom_range(0, 3) == 0 ? 0 :
                  $urandom_range(0, 1) ? 15 : $urandom_range(0, 15)));
  endtask

  initial begin : stimulus
    int unsigned phase_len;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Simple mode after reset: repeated levels and ticks while the timer is idle.
    offer(REQ_LEVEL, 1'b1);
    offer(REQ_LEVEL, 1'b1);
    offer(REQ_LEVEL, 1'b0);
    offer(REQ_LEVEL, 1'b0);
    offer(REQ_TICK, 1'b1);
    offer(REQ_TICK, 1'b0);
    quiesce();

    // All gesture modes with short timers: long press, repeats, double click, timeout.
    write_reg(REG_MODE, 16'd7);
    write_reg(REG_LONGHOLD, 16'd2);
    write_reg(REG_REPEAT_FIRST, 16'd2);
    write_reg(REG_REPEAT, 16'd1);
    write_reg(REG_DBLCLICK, 16'd2);
    offer(REQ_LEVEL, 1'b1);
    ticks(5);
    offer(REQ_LEVEL, 1'b0);
    offer(REQ_LEVEL, 1'b1);
    offer(REQ_LEVEL, 1'b0);
    offer(REQ_LEVEL, 1'b1);
    offer(REQ_LEVEL, 1'b0);
    offer(REQ_LEVEL, 1'b1);
    offer(REQ_LEVEL, 1'b0);
    ticks(2);

    while (sent_words < 1250) begin
      quiesce();
      random_setup();
      phase_len  = $urandom_range(60, 120);
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        if ($urandom_range(0, 9) < 2) begin
          repeat ($urandom_range(1, 4))
            offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          offer(REQ_LEVEL, 1'b1);
          ticks($urandom_range(0, tick_span));
          offer(REQ_LEVEL, 1'b0);
          if ($urandom_range(0, 1)) begin
            ticks($urandom_range(0, 7));
            offer(REQ_LEVEL, 1'b1);
            ticks($urandom_range(0, tick_span));
            offer(REQ_LEVEL, 1'b0);
          end
          ticks($urandom_range(0, 8));
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS button_gesture_detector");
    end else begin
      $display("FAIL button_gesture_detector");
    end
    $finish;
  end

endmodule

`default_nettype wire
